// ===== src/gakf_pkg.sv =====
// Shared constants, types and fixed-point helpers for the angle and bias filter.
`default_nettype none
package gakf_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
	localparam int MAG_BITS  = 2 * WORD_BITS + 1 - FRAC_BITS;
	localparam int CNT_BITS  = $clog2(QUO_BITS);

	localparam int DT_BITS = 17;
	localparam int QN_BITS = 17;
	localparam int R_BITS  = 21;

	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_ANGLE_Q   = 2'd1;
	localparam logic [1:0] REG_BIAS_Q    = 2'd2;
	localparam logic [1:0] REG_MEAS_R    = 2'd3;

	localparam logic [DT_BITS-1:0] DT_RESET = 17'd6554;
	localparam logic [QN_BITS-1:0] QA_RESET = 17'd66;
	localparam logic [QN_BITS-1:0] QB_RESET = 17'd197;
	localparam logic [R_BITS-1:0]  R_RESET  = 21'd32768;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS-1:0] umag_t;
	typedef logic [MAG_BITS-1:0] wmag_t;

	localparam word_t COV_RESET = word_t'(1) <<< (FRAC_BITS - 1);

	localparam logic [4:0] OP_NOP   = 5'd0;
	localparam logic [4:0] OP_LOAD  = 5'd1;
	localparam logic [4:0] OP_DIFF  = 5'd2;
	localparam logic [4:0] OP_MUL   = 5'd3;
	localparam logic [4:0] OP_ANG   = 5'd4;
	localparam logic [4:0] OP_SUMC  = 5'd5;
	localparam logic [4:0] OP_NOISE = 5'd6;
	localparam logic [4:0] OP_P03   = 5'd7;
	localparam logic [4:0] OP_P12   = 5'd8;
	localparam logic [4:0] OP_DEN   = 5'd9;
	localparam logic [4:0] OP_DIV   = 5'd10;
	localparam logic [4:0] OP_ERR   = 5'd11;
	localparam logic [4:0] OP_BIAS  = 5'd12;
	localparam logic [4:0] OP_CAA   = 5'd13;
	localparam logic [4:0] OP_CAB   = 5'd14;
	localparam logic [4:0] OP_CBA   = 5'd15;
	localparam logic [4:0] OP_CBB   = 5'd16;
	localparam logic [4:0] OP_OUT   = 5'd17;

	localparam logic [2:0] MS_DT_TMP  = 3'd0;
	localparam logic [2:0] MS_DT_CBB  = 3'd1;
	localparam logic [2:0] MS_K0_ERR  = 3'd2;
	localparam logic [2:0] MS_K1_ERR  = 3'd3;
	localparam logic [2:0] MS_K0_P0   = 3'd4;
	localparam logic [2:0] MS_K0_P1   = 3'd5;
	localparam logic [2:0] MS_K1_P0   = 3'd6;
	localparam logic [2:0] MS_K1_P1   = 3'd7;

	typedef struct packed {
		logic [4:0] op;
		logic [2:0] msel;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic out_free;
	} sts_t;

	function automatic word_t sat_word(input logic signed [WORD_BITS:0] s);
		word_t r;
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			r = s[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
		end else begin
			r = s[WORD_BITS-1:0];
		end
		return r;
	endfunction

	function automatic umag_t mag(input word_t v);
		umag_t r;
		r = v[WORD_BITS-1] ? umag_t'(-v) : umag_t'(v);
		return r;
	endfunction

	function automatic word_t signed_res(input wmag_t m, input logic neg);
		wmag_t lim;
		wmag_t mm;
		lim = neg ? (wmag_t'(1) << (WORD_BITS - 1)) : ((wmag_t'(1) << (WORD_BITS - 1)) - 1'b1);
		mm = (m > lim) ? lim : m;
		return neg ? word_t'(-mm) : word_t'(mm);
	endfunction

endpackage
`default_nettype wire

// ===== src/gyro_accel_kalman_angle_filter_core.sv =====
// The restoring divider, one quotient bit per cycle, takes up most of the time from the input
// transfer to the result being presented on m_tvalid.
// A new input is taken only once the sequencer is idle again; it can be taken while a result waits.
// Reset: arst_n clears the state to zero angle and bias and a covariance of one half.
// Reset also restores the default sample period, process noises and measurement noise.
`default_nettype none
module gyro_accel_kalman_angle_filter_core
	import gakf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [R_BITS-1:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // gyro_rate [31:0], accel_angle [63:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata    // angle_estimate [31:0]
);

	cmd_t cmd;
	sts_t sts;

	gakf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gakf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
`default_nettype wire

// ===== src/gakf_ctrl.sv =====
// Sequencer that steps the datapath through predict, gain, correct and update.
`default_nettype none
module gakf_ctrl
	import gakf_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  sts_t      sts,
	output cmd_t      cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DIFF = 5'd1;
	localparam logic [4:0] S_M1   = 5'd2;
	localparam logic [4:0] S_A1   = 5'd3;
	localparam logic [4:0] S_SUMC = 5'd4;
	localparam logic [4:0] S_M2   = 5'd5;
	localparam logic [4:0] S_A2   = 5'd6;
	localparam logic [4:0] S_P03  = 5'd7;
	localparam logic [4:0] S_M3   = 5'd8;
	localparam logic [4:0] S_P12  = 5'd9;
	localparam logic [4:0] S_DEN  = 5'd10;
	localparam logic [4:0] S_DIV  = 5'd11;
	localparam logic [4:0] S_ERR  = 5'd12;
	localparam logic [4:0] S_M4   = 5'd13;
	localparam logic [4:0] S_A4   = 5'd14;
	localparam logic [4:0] S_M5   = 5'd15;
	localparam logic [4:0] S_A5   = 5'd16;
	localparam logic [4:0] S_M6   = 5'd17;
	localparam logic [4:0] S_A6   = 5'd18;
	localparam logic [4:0] S_M7   = 5'd19;
	localparam logic [4:0] S_A7   = 5'd20;
	localparam logic [4:0] S_M8   = 5'd21;
	localparam logic [4:0] S_A8   = 5'd22;
	localparam logic [4:0] S_M9   = 5'd23;
	localparam logic [4:0] S_A9   = 5'd24;
	localparam logic [4:0] S_OUT  = 5'd25;

	logic [4:0] state_q;
	logic [4:0] state_nxt;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = OP_NOP;
		cmd.msel = MS_DT_TMP;
		state_nxt = state_q + 5'd1;
		unique case (state_q)
			S_IDLE: begin
				cmd.op = s_tvalid ? OP_LOAD : OP_NOP;
				state_nxt = s_tvalid ? S_DIFF : S_IDLE;
			end
			S_DIFF: cmd.op = OP_DIFF;
			S_M1:   cmd.op = OP_MUL;
			S_A1:   cmd.op = OP_ANG;
			S_SUMC: cmd.op = OP_SUMC;
			S_M2:   cmd.op = OP_MUL;
			S_A2:   cmd.op = OP_NOISE;
			S_P03:  cmd.op = OP_P03;
			S_M3: begin
				cmd.op = OP_MUL;
				cmd.msel = MS_DT_CBB;
			end
			S_P12:  cmd.op = OP_P12;
			S_DEN:  cmd.op = OP_DEN;
			S_DIV: begin
				cmd.op = OP_DIV;
				state_nxt = sts.div_last ? S_ERR : S_DIV;
			end
			S_ERR:  cmd.op = OP_ERR;
			S_M4: begin
				cmd.op = OP_MUL;
				cmd.msel = MS_K0_ERR;
			end
			S_A4:   cmd.op = OP_ANG;
			S_M5: begin
				cmd.op = OP_MUL;
				cmd.msel = MS_K1_ERR;
			end
			S_A5:   cmd.op = OP_BIAS;
			S_M6: begin
				cmd.op = OP_MUL;
				cmd.msel = MS_K0_P0;
			end
			S_A6:   cmd.op = OP_CAA;
			S_M7: begin
				cmd.op = OP_MUL;
				cmd.msel = MS_K0_P1;
			end
			S_A7:   cmd.op = OP_CAB;
			S_M8: begin
				cmd.op = OP_MUL;
				cmd.msel = MS_K1_P0;
			end
			S_A8:   cmd.op = OP_CBA;
			S_M9: begin
				cmd.op = OP_MUL;
				cmd.msel = MS_K1_P1;
			end
			S_A9:   cmd.op = OP_CBB;
			S_OUT: begin
				cmd.op = OP_OUT;
				state_nxt = sts.out_free ? S_IDLE : S_OUT;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef ASSERT_OFF
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && !sts.div_last) |=> (state_q == S_DIV))
		else $error("divide left before its last iteration");
	a_out_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && sts.out_free) |=> (state_q == S_IDLE))
		else $error("result handoff did not return to idle");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && s_tvalid) |=> (state_q == S_DIFF))
		else $error("accepted transfer did not start the sequence");
`endif

endmodule
`default_nettype wire

// ===== src/gakf_dp.sv =====
// Datapath: filter state, configuration, shared multiplier and dual restoring divider.
`default_nettype none
module gakf_dp
	import gakf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [R_BITS-1:0] cfg_data,
	input  wire logic [63:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,
	input  cmd_t             cmd,
	output sts_t             sts
);

	logic [DT_BITS-1:0] dt_q;
	logic [QN_BITS-1:0] qa_q;
	logic [QN_BITS-1:0] qb_q;
	logic [R_BITS-1:0]  r_q;

	word_t ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
	word_t rate_q, meas_q, tmp_q, p0_q, p1_q, p2_q, p3_q, k0_q, k1_q, err_q;
	logic [2*WORD_BITS-1:0] prod_q;
	logic mneg_q;
	umag_t ud_q;
	logic dz_q, dneg0_q, dneg1_q;
	logic [QUO_BITS-1:0] num0_q, num1_q;
	umag_t rem0_q, rem1_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic out_valid_q;
	logic [31:0] out_q;

	word_t ma, mb, mres, den;
	logic [2*WORD_BITS:0] rsum;
	logic [WORD_BITS:0] t0, t1;
	logic ge0, ge1;

	always_comb begin
		unique case (cmd.msel)
			MS_DT_TMP: begin ma = word_t'(dt_q); mb = tmp_q; end
			MS_DT_CBB: begin ma = word_t'(dt_q); mb = cbb_q; end
			MS_K0_ERR: begin ma = k0_q; mb = err_q; end
			MS_K1_ERR: begin ma = k1_q; mb = err_q; end
			MS_K0_P0:  begin ma = k0_q; mb = p0_q; end
			MS_K0_P1:  begin ma = k0_q; mb = p1_q; end
			MS_K1_P0:  begin ma = k1_q; mb = p0_q; end
			MS_K1_P1:  begin ma = k1_q; mb = p1_q; end
			default:   begin ma = k1_q; mb = p1_q; end
		endcase
	end

	assign rsum = {1'b0, prod_q} + ((2*WORD_BITS+1)'(1) << (FRAC_BITS - 1));
	assign mres = signed_res(rsum[2*WORD_BITS:FRAC_BITS], mneg_q);
	assign den  = sat_word({p0_q[WORD_BITS-1], p0_q} + (WORD_BITS+1)'(r_q));

	assign t0  = {rem0_q, num0_q[QUO_BITS-1]};
	assign t1  = {rem1_q, num1_q[QUO_BITS-1]};
	assign ge0 = (t0 >= {1'b0, ud_q});
	assign ge1 = (t1 >= {1'b0, ud_q});

	assign sts.div_last = (cnt_q == CNT_BITS'(QUO_BITS - 1));
	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT && sts.out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= DT_RESET;
			qa_q <= QA_RESET;
			qb_q <= QB_RESET;
			r_q  <= R_RESET;
			ang_q  <= '0;
			bias_q <= '0;
			caa_q <= COV_RESET;
			cab_q <= COV_RESET;
			cba_q <= COV_RESET;
			cbb_q <= COV_RESET;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_addr)
					REG_TIME_STEP: dt_q <= cfg_data[DT_BITS-1:0];
					REG_ANGLE_Q:   qa_q <= cfg_data[QN_BITS-1:0];
					REG_BIAS_Q:    qb_q <= cfg_data[QN_BITS-1:0];
					REG_MEAS_R:    r_q  <= cfg_data;
					default:       r_q  <= cfg_data;
				endcase
			end
			unique case (cmd.op)
				OP_ANG:  ang_q  <= sat_word({ang_q[WORD_BITS-1], ang_q} + {mres[WORD_BITS-1], mres});
				OP_BIAS: bias_q <= sat_word({bias_q[WORD_BITS-1], bias_q} + {mres[WORD_BITS-1], mres});
				OP_CAA:  caa_q <= sat_word({p0_q[WORD_BITS-1], p0_q} - {mres[WORD_BITS-1], mres});
				OP_CAB:  cab_q <= sat_word({p1_q[WORD_BITS-1], p1_q} - {mres[WORD_BITS-1], mres});
				OP_CBA:  cba_q <= sat_word({p2_q[WORD_BITS-1], p2_q} - {mres[WORD_BITS-1], mres});
				OP_CBB:  cbb_q <= sat_word({p3_q[WORD_BITS-1], p3_q} - {mres[WORD_BITS-1], mres});
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				rate_q <= word_t'(signed'(s_tdata[31:0]));
				meas_q <= word_t'(signed'(s_tdata[63:32]));
			end
			OP_DIFF: tmp_q <= sat_word({rate_q[WORD_BITS-1], rate_q} - {bias_q[WORD_BITS-1], bias_q});
			OP_MUL: begin
				prod_q <= mag(ma) * mag(mb);
				mneg_q <= ma[WORD_BITS-1] ^ mb[WORD_BITS-1];
			end
			OP_SUMC: tmp_q <= sat_word({cab_q[WORD_BITS-1], cab_q} + {cba_q[WORD_BITS-1], cba_q});
			OP_NOISE: tmp_q <= sat_word((WORD_BITS+1)'(qa_q) - {mres[WORD_BITS-1], mres});
			OP_P03: begin
				p0_q <= sat_word({caa_q[WORD_BITS-1], caa_q} + {tmp_q[WORD_BITS-1], tmp_q});
				p3_q <= sat_word({cbb_q[WORD_BITS-1], cbb_q} + (WORD_BITS+1)'(qb_q));
			end
			OP_P12: begin
				p1_q <= sat_word({cab_q[WORD_BITS-1], cab_q} - {mres[WORD_BITS-1], mres});
				p2_q <= sat_word({cba_q[WORD_BITS-1], cba_q} - {mres[WORD_BITS-1], mres});
			end
			OP_DEN: begin
				ud_q    <= mag(den);
				dz_q    <= (den == '0);
				dneg0_q <= p0_q[WORD_BITS-1] ^ den[WORD_BITS-1];
				dneg1_q <= p2_q[WORD_BITS-1] ^ den[WORD_BITS-1];
				num0_q  <= {mag(p0_q), {FRAC_BITS{1'b0}}};
				num1_q  <= {mag(p2_q), {FRAC_BITS{1'b0}}};
				rem0_q  <= '0;
				rem1_q  <= '0;
				cnt_q   <= '0;
			end
			OP_DIV: begin
				rem0_q <= ge0 ? umag_t'(t0 - {1'b0, ud_q}) : t0[WORD_BITS-1:0];
				rem1_q <= ge1 ? umag_t'(t1 - {1'b0, ud_q}) : t1[WORD_BITS-1:0];
				num0_q <= {num0_q[QUO_BITS-2:0], ge0};
				num1_q <= {num1_q[QUO_BITS-2:0], ge1};
				cnt_q  <= cnt_q + 1'b1;
			end
			OP_ERR: begin
				k0_q  <= dz_q ? word_t'(0) : signed_res(wmag_t'(num0_q), dneg0_q);
				k1_q  <= dz_q ? word_t'(0) : signed_res(wmag_t'(num1_q), dneg1_q);
				err_q <= sat_word({meas_q[WORD_BITS-1], meas_q} - {ang_q[WORD_BITS-1], ang_q});
			end
			OP_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_q <= 32'(ang_q);
				end
			end
			default: tmp_q <= tmp_q;
		endcase
	end

endmodule
`default_nettype wire
